>>> rtl/core/wfpd_pkg.sv
// Shared types, register codes and reset values for the wall-follow PD mixer.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package wfpd_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int GAIN_BITS       = 16;
    localparam int DUTY_BITS       = 15;
    localparam int LEVEL_BITS      = 12;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_DERIV_GAIN = 3'd1,
        CFG_BASE_DUTY  = 3'd2,
        CFG_SLOW_DUTY  = 3'd3,
        CFG_MAX_DUTY   = 3'd4,
        CFG_MIN_DUTY   = 3'd5,
        CFG_OPEN_LEVEL = 3'd6,
        CFG_CORNER_LVL = 3'd7
    } cfg_index_t;

    localparam logic [GAIN_BITS-1:0]  PROP_GAIN_RST  = 16'd524;
    localparam logic [GAIN_BITS-1:0]  DERIV_GAIN_RST = 16'd328;
    localparam logic [DUTY_BITS-1:0]  BASE_DUTY_RST  = 15'd10240;
    localparam logic [DUTY_BITS-1:0]  SLOW_DUTY_RST  = 15'd3840;
    localparam logic [DUTY_BITS-1:0]  MAX_DUTY_RST   = 15'd17920;
    localparam logic [DUTY_BITS-1:0]  MIN_DUTY_RST   = 15'd0;
    localparam logic [LEVEL_BITS-1:0] OPEN_LEVEL_RST = 12'd3500;
    localparam logic [LEVEL_BITS-1:0] CORNER_LVL_RST = 12'd2500;

    typedef struct packed {
        logic [GAIN_BITS-1:0]  prop_gain;
        logic [GAIN_BITS-1:0]  deriv_gain_per_tick;
        logic [DUTY_BITS-1:0]  base_duty;
        logic [DUTY_BITS-1:0]  slow_duty;
        logic [DUTY_BITS-1:0]  max_duty;
        logic [DUTY_BITS-1:0]  min_duty;
        logic [LEVEL_BITS-1:0] open_side_level;
        logic [LEVEL_BITS-1:0] corner_level;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] left_drive;
        logic [DUTY_BITS-1:0] right_drive;
        logic                 walls_missing;
        logic                 slowed;
    } drive_res_t;

endpackage

`default_nettype wire

>>> rtl/core/wfpd_if.sv
// Valid/ready channel interfaces: sensor sample set in, motor drive result out.
// Depends on wfpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wfpd_sample_if #(
    parameter int SAMPLE_BITS = wfpd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] right_side;
    logic [SAMPLE_BITS-1:0] left_side;
    logic [SAMPLE_BITS-1:0] left_diagonal;
    logic [SAMPLE_BITS-1:0] right_diagonal;

    modport source (output valid, right_side, left_side, left_diagonal, right_diagonal,
                    input ready);
    modport sink   (input valid, right_side, left_side, left_diagonal, right_diagonal,
                    output ready);
endinterface

interface wfpd_drive_if;
    logic                           valid;
    logic                           ready;
    logic [wfpd_pkg::DUTY_BITS-1:0] left_drive;
    logic [wfpd_pkg::DUTY_BITS-1:0] right_drive;
    logic                           walls_missing;
    logic                           slowed;

    modport source (output valid, left_drive, right_drive, walls_missing, slowed,
                    input ready);
    modport sink   (input valid, left_drive, right_drive, walls_missing, slowed,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/wfpd_cfg.sv
// Configuration register bank for the wall-follow PD mixer.
// Depends on wfpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfpd_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [wfpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [wfpd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output wfpd_pkg::cfg_t                           cfg
);
    import wfpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PROP_GAIN:  cfg_next.prop_gain           = cfg_wdata[GAIN_BITS-1:0];
                CFG_DERIV_GAIN: cfg_next.deriv_gain_per_tick = cfg_wdata[GAIN_BITS-1:0];
                CFG_BASE_DUTY:  cfg_next.base_duty           = cfg_wdata[DUTY_BITS-1:0];
                CFG_SLOW_DUTY:  cfg_next.slow_duty           = cfg_wdata[DUTY_BITS-1:0];
                CFG_MAX_DUTY:   cfg_next.max_duty            = cfg_wdata[DUTY_BITS-1:0];
                CFG_MIN_DUTY:   cfg_next.min_duty            = cfg_wdata[DUTY_BITS-1:0];
                CFG_OPEN_LEVEL: cfg_next.open_side_level     = cfg_wdata[LEVEL_BITS-1:0];
                CFG_CORNER_LVL: cfg_next.corner_level        = cfg_wdata[LEVEL_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain           <= PROP_GAIN_RST;
            cfg_reg.deriv_gain_per_tick <= DERIV_GAIN_RST;
            cfg_reg.base_duty           <= BASE_DUTY_RST;
            cfg_reg.slow_duty           <= SLOW_DUTY_RST;
            cfg_reg.max_duty            <= MAX_DUTY_RST;
            cfg_reg.min_duty            <= MIN_DUTY_RST;
            cfg_reg.open_side_level     <= OPEN_LEVEL_RST;
            cfg_reg.corner_level        <= CORNER_LVL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/wfpd_calc.sv
// PD correction and differential duty mixing, one sample set per call.
// Purely combinational; depends on wfpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfpd_calc #(
    parameter int SAMPLE_BITS = wfpd_pkg::SAMPLE_BITS_DEF
) (
    input  wire wfpd_pkg::cfg_t           cfg,
    input  wire logic [SAMPLE_BITS-1:0]   right_side,
    input  wire logic [SAMPLE_BITS-1:0]   left_side,
    input  wire logic [SAMPLE_BITS-1:0]   left_diagonal,
    input  wire logic [SAMPLE_BITS-1:0]   right_diagonal,
    input  wire logic signed [SAMPLE_BITS:0] prev_error,
    output logic signed [SAMPLE_BITS:0]   error_next,
    output wfpd_pkg::drive_res_t          res
);
    import wfpd_pkg::*;

    localparam int EW = SAMPLE_BITS + 1;            // error
    localparam int XW = SAMPLE_BITS + 2;            // error delta
    localparam int PW = EW + GAIN_BITS + 1;         // kp * error
    localparam int QW = XW + GAIN_BITS + 1;         // kd * delta
    localparam int SW = QW + 2;                     // rounded sum
    localparam int CW = SW - 8;                     // Q8 correction
    localparam int DW = CW + 2;                     // duty arithmetic
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(128);

    logic                 missing;
    logic                 slow;
    logic signed [EW-1:0] err;
    logic signed [XW-1:0] delta;
    logic signed [PW-1:0] prod_p;
    logic signed [QW-1:0] prod_d;
    logic signed [SW-1:0] sum;
    logic signed [CW-1:0] corr;
    logic signed [DW-1:0] base_ext;
    logic signed [DW-1:0] corr_ext;

    function automatic logic [DUTY_BITS-1:0] clamp_duty(
        input logic signed [DW-1:0] d,
        input logic [DUTY_BITS-1:0] hi,
        input logic [DUTY_BITS-1:0] lo
    );
        logic signed [DW-1:0] hi_ext;
        logic signed [DW-1:0] lo_ext;
        logic signed [DW-1:0] v;
        hi_ext = $signed({{(DW-DUTY_BITS){1'b0}}, hi});
        lo_ext = $signed({{(DW-DUTY_BITS){1'b0}}, lo});
        v = d;
        if (v > hi_ext)
            v = hi_ext;
        if (v < lo_ext)
            v = lo_ext;      // min wins on crossed clamps
        return v[DUTY_BITS-1:0];
    endfunction

    always_comb
    begin
        slow    = (left_diagonal > cfg.corner_level) || (right_diagonal > cfg.corner_level);
        missing = (left_side > cfg.open_side_level) && (right_side > cfg.open_side_level);

        err    = $signed({1'b0, right_side}) - $signed({1'b0, left_side});
        delta  = $signed({err[EW-1], err}) - $signed({prev_error[EW-1], prev_error});
        prod_p = $signed({1'b0, cfg.prop_gain}) * err;
        prod_d = $signed({1'b0, cfg.deriv_gain_per_tick}) * delta;
        sum    = SW'(prod_p) + SW'(prod_d) + ROUND_HALF;
        // arithmetic shift gives floor division by 256
        corr   = missing ? '0 : $signed(sum[SW-1:8]);

        base_ext = $signed({{(DW-DUTY_BITS){1'b0}},
                            (slow ? cfg.slow_duty : cfg.base_duty)});
        corr_ext = DW'(corr);

        res.left_drive    = clamp_duty(base_ext + corr_ext, cfg.max_duty, cfg.min_duty);
        res.right_drive   = clamp_duty(base_ext - corr_ext, cfg.max_duty, cfg.min_duty);
        res.walls_missing = missing;
        res.slowed        = slow;

        error_next = missing ? '0 : err;
    end

endmodule

`default_nettype wire

>>> rtl/core/wall_follow_pd_motor_mixer_core.sv
// Wall-follow PD steering with differential motor duty mixing.
// Flow: a sample set is captured in the input register, its result is then
// loaded into the result register and transfers out from there.
// Throughput: one sample set per cycle unless the drive side stalls; set by
// the combinational PD/mixer path closing through the previous-error register.
// Reset: async active low; config registers take their defaults, previous
// error clears to zero and both channel stages empty.
`timescale 1ns / 1ps
`default_nettype none

module wall_follow_pd_motor_mixer_core #(
    parameter int SAMPLE_BITS = wfpd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [wfpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [wfpd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    wfpd_sample_if.sink                              sample,
    wfpd_drive_if.source                             drive
);
    import wfpd_pkg::*;

    // ---------------------------------------------------------------
    // Configuration bank
    // ---------------------------------------------------------------
    cfg_t cfg;

    wfpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ---------------------------------------------------------------
    // Two-stage flow: input register -> compute -> result register.
    // The input stage refills whenever it moves on, so a stalled result
    // register still lets one more transfer land.
    // ---------------------------------------------------------------
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic take;

    logic [SAMPLE_BITS-1:0] right_reg, left_reg, ldiag_reg, rdiag_reg;

    logic signed [SAMPLE_BITS:0] prev_error_reg, prev_error_next;
    logic signed [SAMPLE_BITS:0] error_calc;
    drive_res_t                  res_calc;
    drive_res_t                  res_reg;

    assign advance      = !out_valid_reg || drive.ready;
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    always_comb
    begin
        in_valid_next   = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next  = advance ? in_valid_reg : out_valid_reg;
        // error history only moves when the item leaves the input stage
        prev_error_next = (advance && in_valid_reg) ? error_calc : prev_error_reg;
    end

    wfpd_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_calc (
        .cfg            (cfg),
        .right_side     (right_reg),
        .left_side      (left_reg),
        .left_diagonal  (ldiag_reg),
        .right_diagonal (rdiag_reg),
        .prev_error     (prev_error_reg),
        .error_next     (error_calc),
        .res            (res_calc)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_error_reg <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            prev_error_reg <= prev_error_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            right_reg <= sample.right_side;
            left_reg  <= sample.left_side;
            ldiag_reg <= sample.left_diagonal;
            rdiag_reg <= sample.right_diagonal;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_calc;
        end
    end

    // ---------------------------------------------------------------
    // Result channel
    // ---------------------------------------------------------------
    assign drive.valid         = out_valid_reg;
    assign drive.left_drive    = res_reg.left_drive;
    assign drive.right_drive   = res_reg.right_drive;
    assign drive.walls_missing = res_reg.walls_missing;
    assign drive.slowed        = res_reg.slowed;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench top for wall_follow_pd_motor_mixer_core: drives sensor sets and
// register writes, predicts every drive result and checks it on transfer.
// Depends on wfpd_pkg and the wfpd_sample_if / wfpd_drive_if interfaces.
`timescale 1ns / 1ps

module tb_top;
    import wfpd_pkg::*;

    // ------------------------------------------------------------------
    // Predicts motor duties from accepted sensor sets and holds them until
    // the matching drive transfer comes out of the block.
    // ------------------------------------------------------------------
    class duty_tracker;
        cfg_t               regs;
        logic signed [12:0] last_err;
        drive_res_t         due_drives[$];
        int                 failures;

        function new();
            regs.prop_gain           = PROP_GAIN_RST;
            regs.deriv_gain_per_tick = DERIV_GAIN_RST;
            regs.base_duty           = BASE_DUTY_RST;
            regs.slow_duty           = SLOW_DUTY_RST;
            regs.max_duty            = MAX_DUTY_RST;
            regs.min_duty            = MIN_DUTY_RST;
            regs.open_side_level     = OPEN_LEVEL_RST;
            regs.corner_level        = CORNER_LVL_RST;
            last_err = '0;
            failures = 0;
        endfunction

        // Register bits above each register's width are dropped.
        function void set_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] v);
            case (idx)
                CFG_PROP_GAIN:  regs.prop_gain           = v[GAIN_BITS-1:0];
                CFG_DERIV_GAIN: regs.deriv_gain_per_tick = v[GAIN_BITS-1:0];
                CFG_BASE_DUTY:  regs.base_duty           = v[DUTY_BITS-1:0];
                CFG_SLOW_DUTY:  regs.slow_duty           = v[DUTY_BITS-1:0];
                CFG_MAX_DUTY:   regs.max_duty            = v[DUTY_BITS-1:0];
                CFG_MIN_DUTY:   regs.min_duty            = v[DUTY_BITS-1:0];
                CFG_OPEN_LEVEL: regs.open_side_level     = v[LEVEL_BITS-1:0];
                CFG_CORNER_LVL: regs.corner_level        = v[LEVEL_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Max clamp first, then min; min wins when the two cross.
        function logic [DUTY_BITS-1:0] clamp_duty(longint d);
            if (d > longint'(regs.max_duty))
                d = longint'(regs.max_duty);
            if (d < longint'(regs.min_duty))
                d = longint'(regs.min_duty);
            return d[DUTY_BITS-1:0];
        endfunction

        function void take_sample(logic [11:0] rs, logic [11:0] ls,
                                  logic [11:0] ld, logic [11:0] rd);
            longint     err;
            longint     delta;
            longint     sum;
            longint     corr;
            longint     base;
            logic       slow;
            logic       open;
            drive_res_t exp_drive;
            slow = (ld > regs.corner_level) || (rd > regs.corner_level);
            open = (ls > regs.open_side_level) && (rs > regs.open_side_level);
            base = slow ? longint'(regs.slow_duty) : longint'(regs.base_duty);
            corr = 0;
            if (open)
                last_err = '0;
            else
            begin
                err   = longint'(rs) - longint'(ls);
                delta = err - longint'(last_err);
                sum   = longint'(regs.prop_gain) * err
                      + longint'(regs.deriv_gain_per_tick) * delta;
                // Q16 to Q8, round half up
                corr     = (sum + 128) >>> 8;
                last_err = err[12:0];
            end
            exp_drive.left_drive    = clamp_duty(base + corr);
            exp_drive.right_drive   = clamp_duty(base - corr);
            exp_drive.walls_missing = open;
            exp_drive.slowed        = slow;
            due_drives.push_back(exp_drive);
        endfunction

        function void check_drive(drive_res_t got);
            drive_res_t want;
            if (due_drives.size() == 0)
            begin
                $error("drive transfer with no expected result: %p", got);
                failures++;
                return;
            end
            want = due_drives.pop_front();
            if (got.left_drive !== want.left_drive)
            begin
                $error("left_drive: expected %0d, got %0d", want.left_drive, got.left_drive);
                failures++;
            end
            if (got.right_drive !== want.right_drive)
            begin
                $error("right_drive: expected %0d, got %0d",
                       want.right_drive, got.right_drive);
                failures++;
            end
            if (got.walls_missing !== want.walls_missing)
            begin
                $error("walls_missing: expected %0b, got %0b",
                       want.walls_missing, got.walls_missing);
                failures++;
            end
            if (got.slowed !== want.slowed)
            begin
                $error("slowed: expected %0b, got %0b", want.slowed, got.slowed);
                failures++;
            end
        endfunction

        function int pending();
            return due_drives.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block itself
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    wfpd_sample_if sample_ch ();
    wfpd_drive_if  drive_ch ();

    wall_follow_pd_motor_mixer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_ch),
        .drive     (drive_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    duty_tracker duties = new();

    // Set by the stimulus to drop idling on both sides for a stretch.
    bit no_idle   = 1'b0;
    // Set by the stimulus; the drive side then holds ready low for a long
    // stretch so the pipeline fills and the sample side backs up.
    bit hold_back = 1'b0;

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge. The sample note
    // comes first, though with the input and result registers in between a drive
    // transfer can never belong to a sample taken at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
            duties.take_sample(sample_ch.right_side, sample_ch.left_side,
                               sample_ch.left_diagonal, sample_ch.right_diagonal);
        if (rst_n && drive_ch.valid && drive_ch.ready)
            duties.check_drive('{left_drive:    drive_ch.left_drive,
                                 right_drive:   drive_ch.right_drive,
                                 walls_missing: drive_ch.walls_missing,
                                 slowed:        drive_ch.slowed});
    end

    // ------------------------------------------------------------------
    // Drive side: random stall before each result, plus the long
    // hold-off on request. All changes at the falling edge.
    // ------------------------------------------------------------------
    initial
    begin : drive_sink
        int stall;
        drive_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_back)
            begin
                hold_back = 1'b0;
                stall = 400;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                drive_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            drive_ch.ready <= 1'b1;
            do @(posedge clk); while (!drive_ch.valid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sample side. Called at a falling edge, returns at the falling edge
    // after the transfer with valid still high, so back-to-back sets never
    // drop and re-raise valid within one step.
    // ------------------------------------------------------------------
    task automatic send_sample(logic [11:0] rs, logic [11:0] ls,
                               logic [11:0] ld, logic [11:0] rd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.right_side     <= rs;
        sample_ch.left_side      <= ls;
        sample_ch.left_diagonal  <= ld;
        sample_ch.right_diagonal <= rd;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
    endtask

    // One register write per cycle; the caller lowers cfg_we afterwards.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        duties.set_reg(idx, v);
    endtask

    task automatic apply_setting(logic [15:0] pg, logic [15:0] dg,
                                 logic [15:0] bd, logic [15:0] sd,
                                 logic [15:0] mx, logic [15:0] mn,
                                 logic [15:0] ol, logic [15:0] cl);
        write_reg(CFG_PROP_GAIN,  pg);
        write_reg(CFG_DERIV_GAIN, dg);
        write_reg(CFG_BASE_DUTY,  bd);
        write_reg(CFG_SLOW_DUTY,  sd);
        write_reg(CFG_MAX_DUTY,   mx);
        write_reg(CFG_MIN_DUTY,   mn);
        write_reg(CFG_OPEN_LEVEL, ol);
        write_reg(CFG_CORNER_LVL, cl);
        cfg_we <= 1'b0;
    endtask

    // Reading biased towards a threshold: its neighbours, above it, the
    // rails, or anything at all.
    function automatic logic [11:0] pick_reading(logic [11:0] lvl);
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 1) ? 4095 : 0;
            1: v = int'(lvl) + $urandom_range(0, 2) - 1;
            2: v = $urandom_range(int'(lvl), 4095);
            default: v = $urandom_range(0, 4095);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    // Random sets; idling switched off now and then for a stretch.
    task automatic send_random(int count);
        logic [11:0] ol;
        logic [11:0] cl;
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            ol = duties.regs.open_side_level;
            cl = duties.regs.corner_level;
            send_sample(pick_reading(ol), pick_reading(ol),
                        pick_reading(cl), pick_reading(cl));
        end
        no_idle = 1'b0;
    endtask

    // Long receiver hold-off with the sender pushing flat out behind it.
    task automatic send_backlog();
        hold_back = 1'b1;
        no_idle   = 1'b1;
        for (int i = 0; i < 40; i++)
            send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                        12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        no_idle = 1'b0;
    endtask

    // Lower valid and let every outstanding result out, so the block is
    // idle before registers change.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (duties.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = CFG_PROP_GAIN;
        cfg_wdata                = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.right_side     = '0;
        sample_ch.left_side      = '0;
        sample_ch.left_diagonal  = '0;
        sample_ch.right_diagonal = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed sets at reset settings
        send_sample(12'd0,    12'd0,    12'd0,    12'd0);
        send_sample(12'd4095, 12'd0,    12'd0,    12'd0);    // full right error
        send_sample(12'd0,    12'd4095, 12'd0,    12'd0);    // full left, big derivative
        send_sample(12'd2000, 12'd1000, 12'd100,  12'd100);
        send_sample(12'd1000, 12'd2000, 12'd100,  12'd100);
        send_sample(12'd3501, 12'd3501, 12'd0,    12'd0);    // walls missing
        send_sample(12'd1500, 12'd1200, 12'd0,    12'd0);    // error restarts from zero
        send_sample(12'd3500, 12'd3500, 12'd0,    12'd0);    // at level: not open
        send_sample(12'd3501, 12'd3500, 12'd0,    12'd0);    // one side only
        send_sample(12'd3500, 12'd3501, 12'd0,    12'd0);
        send_sample(12'd2000, 12'd2000, 12'd2501, 12'd0);    // left diagonal slows
        send_sample(12'd2000, 12'd2000, 12'd0,    12'd2501); // right diagonal slows
        send_sample(12'd2000, 12'd2000, 12'd2500, 12'd2500); // at level: no slow
        send_sample(12'd4095, 12'd4095, 12'd4095, 12'd4095); // open and slowed
        send_sample(12'd3000, 12'd10,   12'd4095, 12'd0);    // slow, right side clamps at min
        send_sample(12'd10,   12'd3000, 12'd0,    12'd4095); // slow, clamp at min
        send_sample(12'hAAA,  12'h555,  12'h555,  12'hAAA);
        send_sample(12'h555,  12'hAAA,  12'hAAA,  12'h555);
        send_sample(12'd1,    12'd0,    12'd0,    12'd0);    // smallest error
        send_sample(12'd0,    12'd1,    12'd0,    12'd0);
        send_random(100);
        send_backlog();
        drain();

        // Largest gains and duties; thresholds at the top, so never open
        // and never slowed.
        apply_setting(16'hFFFF, 16'hFFFF, 16'd25600, 16'd0,
                      16'd25600, 16'd0, 16'd4095, 16'd4095);
        send_random(90);
        drain();

        // All zero but the slow duty: no gain, zero clamps, thresholds at the bottom.
        apply_setting(16'd0, 16'd0, 16'd0, 16'd25600,
                      16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(12'd0, 12'd0, 12'd0, 12'd0);
        send_sample(12'd1, 12'd1, 12'd1, 12'd1);
        send_random(90);
        drain();

        // Crossed clamps: min above max, so min wins.
        apply_setting(16'd524, 16'd328, 16'd10240, 16'd3840,
                      16'd5000, 16'd20000, 16'd3500, 16'd2500);
        send_random(90);
        drain();

        // Bits above each register's width are dropped.
        apply_setting(16'hFFFF, 16'h8001, 16'hFFFF, 16'hC000,
                      16'hFFFF, 16'h8000, 16'hF800, 16'hFFFF);
        send_random(90);
        send_backlog();
        drain();

        // Random settings
        for (int p = 0; p < 4; p++)
        begin
            apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 25600)), 16'($urandom_range(0, 25600)),
                          16'($urandom_range(12800, 25600)), 16'($urandom_range(0, 12800)),
                          16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)));
            send_random(80);
            drain();
        end

        // Back to the reset values
        apply_setting(16'(PROP_GAIN_RST), 16'(DERIV_GAIN_RST),
                      16'(BASE_DUTY_RST), 16'(SLOW_DUTY_RST),
                      16'(MAX_DUTY_RST), 16'(MIN_DUTY_RST),
                      16'(OPEN_LEVEL_RST), 16'(CORNER_LVL_RST));
        send_random(60);
        drain();

        repeat (10) @(posedge clk);
        if (duties.failures == 0 && duties.pending() == 0)
            $display("wall_follow_pd_motor_mixer_core test passed");
        else
            $display("wall_follow_pd_motor_mixer_core test failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin : watchdog
        #4_000_000;
        $display("wall_follow_pd_motor_mixer_core test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/wfpd_pkg.sv
rtl/core/wfpd_if.sv
rtl/core/wfpd_cfg.sv
rtl/core/wfpd_calc.sv
rtl/core/wall_follow_pd_motor_mixer_core.sv
tb/tb_top.sv
